// ===== hdl/acia_pkg.sv =====
// ----------------------------------------------------------------------------
// acia_pkg
// shared types and constants of the acia host register interface
// ----------------------------------------------------------------------------
package acia_pkg;

  typedef enum logic [1:0] {
    OP_BUS_WRITE = 2'd0,
    OP_BUS_READ  = 2'd1,
    OP_RX_CHAR   = 2'd2,
    OP_POLL      = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ADDR_CTRL_STAT = 2'd0,
    ADDR_DATA      = 2'd1,
    ADDR_DIV_LO    = 2'd2,
    ADDR_DIV_HI    = 2'd3
  } addr_e;

  localparam logic [15:0] DivisorDefault = 16'd95;

  localparam logic [7:0] CtrlRxIrqMask = 8'h80;
  localparam logic [7:0] CtrlTxMask    = 8'h60;
  localparam logic [7:0] CtrlResetMask = 8'h03;
  localparam logic [1:0] CtrlTxRts     = 2'b10;
  localparam logic [1:0] CtrlTxIrq     = 2'b01;
  localparam logic [7:0] StatTxClr     = 8'b0111_1101;
  localparam logic [7:0] StatRdClr     = 8'b0111_1110;
  localparam logic [7:0] StatPollKeep  = 8'b1110_0001;
  localparam logic [7:0] StatRxKeep    = 8'b0000_1110;

  // one result item
  typedef struct packed {
    logic [7:0]  read_data;
    logic        irq_n;
    logic        rts_out;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        send_break;
    logic        uart_enable;
    logic        fast_divider;
    logic [1:0]  frame_format;
    logic [15:0] baud_divisor;
    logic        rx_pop;
    logic        overrun_clear;
  } rslt_t;

endpackage

// ===== hdl/acia_core.sv =====
// ----------------------------------------------------------------------------
// acia_core
// register file and single-pass update logic for one item
// ----------------------------------------------------------------------------
module acia_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  logic [1:0]            operation_i,
  input  logic [1:0]            address_i,
  input  logic [7:0]            write_data_i,
  input  logic [7:0]            rx_byte_i,
  input  logic                  framing_error_i,
  input  logic                  overrun_error_i,
  input  logic                  parity_error_i,
  input  logic                  carrier_detect_n_i,
  input  logic                  clear_to_send_n_i,
  input  logic                  transmitter_idle_i,
  input  logic                  rx_more_available_i,
  output acia_pkg::rslt_t       result_o
);
  import acia_pkg::*;

  logic [7:0]  control_q, control_d;
  logic [7:0]  status_q, status_d;
  logic [7:0]  rx_data_q, rx_data_d;
  logic [15:0] div_shadow_q, div_shadow_d;
  logic [15:0] div_active_q, div_active_d;
  logic [7:0]  prev_status_q, prev_status_d;
  logic        enabled_q, enabled_d;

  logic [7:0]  rd;
  logic        txv, brk, pop, oclr;
  logic [7:0]  txb;
  logic [7:0]  poll_s;
  logic        rx_arm, tx_arm;
  op_e         op;
  addr_e       addr;

  assign op   = op_e'(operation_i);
  assign addr = addr_e'(address_i);

  // poll tick status, armed by the previous tick's status
  always_comb begin
    rx_arm = control_q[7] && !prev_status_q[2];
    tx_arm = (control_q[6:5] == CtrlTxIrq) && !prev_status_q[1];
    poll_s = status_q & StatPollKeep;
    if (!clear_to_send_n_i) begin
      poll_s[1] = transmitter_idle_i;
    end
    poll_s[2] = carrier_detect_n_i;
    poll_s[3] = clear_to_send_n_i;
    poll_s[4] = framing_error_i;
    if ((rx_arm && poll_s[2]) || (tx_arm && poll_s[1])) begin
      poll_s[7] = 1'b1;
    end
  end

  always_comb begin
    control_d     = control_q;
    status_d      = status_q;
    rx_data_d     = rx_data_q;
    div_shadow_d  = div_shadow_q;
    div_active_d  = div_active_q;
    prev_status_d = prev_status_q;
    enabled_d     = enabled_q;
    rd   = 8'd0;
    txv  = 1'b0;
    txb  = 8'd0;
    brk  = 1'b0;
    pop  = 1'b0;
    oclr = 1'b0;
    case (op)
      OP_BUS_WRITE: begin
        case (addr)
          ADDR_CTRL_STAT: begin
            control_d = write_data_i;
            if ((write_data_i & CtrlResetMask) == CtrlResetMask) begin
              div_active_d = div_shadow_q;
              enabled_d    = 1'b1;
            end else if ((write_data_i & CtrlTxMask) == CtrlTxMask && enabled_q) begin
              brk = 1'b1;
              txv = 1'b1;
            end
          end
          ADDR_DATA: begin
            txv      = 1'b1;
            txb      = write_data_i;
            status_d = status_q & StatTxClr;
          end
          ADDR_DIV_LO: div_shadow_d = {div_shadow_q[15:8], write_data_i};
          default:     div_shadow_d = {write_data_i, div_shadow_q[7:0]};
        endcase
      end
      OP_BUS_READ: begin
        case (addr)
          ADDR_CTRL_STAT: rd = status_q;
          ADDR_DATA: begin
            rd = rx_data_q;
            if (rx_more_available_i) begin
              rx_data_d = rx_byte_i;
              pop       = 1'b1;
            end
            status_d = (status_q & StatRdClr) | {7'd0, rx_more_available_i};
            oclr     = 1'b1;
          end
          ADDR_DIV_LO: rd = div_shadow_q[7:0];
          default:     rd = div_shadow_q[15:8];
        endcase
      end
      OP_RX_CHAR: begin
        if (!status_q[0]) begin
          rx_data_d = rx_byte_i;
          pop       = 1'b1;
        end
        status_d = (status_q & StatRxKeep) | (control_q & CtrlRxIrqMask) |
                   {1'b0, parity_error_i, overrun_error_i, framing_error_i, 4'b0001};
      end
      default: begin
        status_d      = poll_s;
        prev_status_d = poll_s;
      end
    endcase
  end

  // outputs that follow registers show the value after this item
  always_comb begin
    result_o.read_data     = rd;
    result_o.irq_n         = !status_d[7];
    result_o.rts_out       = (control_d[6:5] == CtrlTxRts);
    result_o.tx_valid      = txv;
    result_o.tx_byte       = txb;
    result_o.send_break    = brk;
    result_o.uart_enable   = enabled_d;
    result_o.fast_divider  = (control_d[1:0] == 2'b00);
    result_o.frame_format  = control_d[3:2];
    result_o.baud_divisor  = div_active_d;
    result_o.rx_pop        = pop;
    result_o.overrun_clear = oclr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      control_q     <= 8'd0;
      status_q      <= 8'd0;
      rx_data_q     <= 8'd0;
      div_shadow_q  <= DivisorDefault;
      div_active_q  <= DivisorDefault;
      prev_status_q <= 8'd0;
      enabled_q     <= 1'b0;
    end else if (accept_i) begin
      control_q     <= control_d;
      status_q      <= status_d;
      rx_data_q     <= rx_data_d;
      div_shadow_q  <= div_shadow_d;
      div_active_q  <= div_active_d;
      prev_status_q <= prev_status_d;
      enabled_q     <= enabled_d;
    end
  end

`ifndef SYNTH
  // the enable flag never drops once set
  a_enable_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(enabled_q) |-> enabled_q)
    else $error("uart enable dropped");

  // a break always carries a zero transmit byte
  a_break_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.send_break |-> (result_o.tx_valid && result_o.tx_byte == 8'd0))
    else $error("break with nonzero byte");

  // state only moves on an accepted item
  a_hold_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(accept_i) |-> ($stable(status_q) && $stable(control_q)))
    else $error("state changed without an item");
`endif

endmodule

// ===== hdl/acia_obuf.sv =====
// ----------------------------------------------------------------------------
// acia_obuf
// two-entry result buffer: output register plus skid register
// ----------------------------------------------------------------------------
module acia_obuf (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  acia_pkg::rslt_t  data_i,
  output logic             ready_o,
  output logic             valid_o,
  input  logic             ready_i,
  output acia_pkg::rslt_t  data_o
);
  import acia_pkg::*;

  logic  main_vld_q, skid_vld_q;
  rslt_t main_q, skid_q;
  logic  pop;

  assign pop     = main_vld_q && ready_i;
  assign ready_o = !skid_vld_q;
  assign valid_o = main_vld_q;
  assign data_o  = main_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_vld_q <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      if (skid_vld_q) begin
        if (pop) begin
          main_vld_q <= 1'b1;
          skid_vld_q <= 1'b0;
        end
      end else if (push_i) begin
        if (!main_vld_q || pop) begin
          main_vld_q <= 1'b1;
        end else begin
          skid_vld_q <= 1'b1;
        end
      end else if (pop) begin
        main_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (pop) begin
        main_q <= skid_q;
      end
    end else if (push_i) begin
      if (!main_vld_q || pop) begin
        main_q <= data_i;
      end else begin
        skid_q <= data_i;
      end
    end
  end

`ifndef SYNTH
  // skid entry only holds data behind a full output register
  a_skid_behind_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> main_vld_q)
    else $error("skid full with empty output register");

  // a stalled skid entry moves forward on the next pop
  a_skid_forward: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_vld_q && pop) |=> (main_vld_q && !skid_vld_q))
    else $error("skid entry not forwarded");

  // a push into a full, stalled output register lands in the skid
  a_push_to_skid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && main_vld_q && !ready_i) |=> skid_vld_q)
    else $error("item lost on stall");
`endif

endmodule

// ===== hdl/acia_register_interface.sv =====
// ----------------------------------------------------------------------------
// acia_register_interface
// host register file of a 6850-style acia with a 16-bit baud divisor
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+-------------------------------
//   in      | input     | in_valid_i / in_ready_o | bus access, rx character, poll
//   out     | output    | out_valid_o/out_ready_i | read data, pins, strobes
//
// one item per cycle while in_ready_o is high: each item is decoded and the
// register file updated in the cycle it is accepted, and its result is
// registered into the output stage
// reset clears control, status and data registers; the divisor comes up at 95
// a two-entry output buffer lets a new item in while a result waits; input
// ready drops only when both entries hold results
//
module acia_register_interface (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  operation_i,
  input  logic [1:0]  address_i,
  input  logic [7:0]  write_data_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        framing_error_i,
  input  logic        overrun_error_i,
  input  logic        parity_error_i,
  input  logic        carrier_detect_n_i,
  input  logic        clear_to_send_n_i,
  input  logic        transmitter_idle_i,
  input  logic        rx_more_available_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  read_data_o,
  output logic        irq_n_o,
  output logic        rts_out_o,
  output logic        tx_valid_o,
  output logic [7:0]  tx_byte_o,
  output logic        send_break_o,
  output logic        uart_enable_o,
  output logic        fast_divider_o,
  output logic [1:0]  frame_format_o,
  output logic [15:0] baud_divisor_o,
  output logic        rx_pop_o,
  output logic        overrun_clear_o
);
  import acia_pkg::*;

  logic  accept;
  rslt_t core_rslt;
  rslt_t out_rslt;

  // an item is taken when it is offered and the result buffer has room
  assign accept = in_valid_i && in_ready_o;

  // register file and per-item update
  acia_core u_core (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .accept_i            (accept),
    .operation_i         (operation_i),
    .address_i           (address_i),
    .write_data_i        (write_data_i),
    .rx_byte_i           (rx_byte_i),
    .framing_error_i     (framing_error_i),
    .overrun_error_i     (overrun_error_i),
    .parity_error_i      (parity_error_i),
    .carrier_detect_n_i  (carrier_detect_n_i),
    .clear_to_send_n_i   (clear_to_send_n_i),
    .transmitter_idle_i  (transmitter_idle_i),
    .rx_more_available_i (rx_more_available_i),
    .result_o            (core_rslt)
  );

  // result register with skid entry
  acia_obuf u_obuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .data_i  (core_rslt),
    .ready_o (in_ready_o),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (out_rslt)
  );

  // unpack the result item onto its ports
  assign read_data_o     = out_rslt.read_data;
  assign irq_n_o         = out_rslt.irq_n;
  assign rts_out_o       = out_rslt.rts_out;
  assign tx_valid_o      = out_rslt.tx_valid;
  assign tx_byte_o       = out_rslt.tx_byte;
  assign send_break_o    = out_rslt.send_break;
  assign uart_enable_o   = out_rslt.uart_enable;
  assign fast_divider_o  = out_rslt.fast_divider;
  assign frame_format_o  = out_rslt.frame_format;
  assign baud_divisor_o  = out_rslt.baud_divisor;
  assign rx_pop_o        = out_rslt.rx_pop;
  assign overrun_clear_o = out_rslt.overrun_clear;

endmodule
